/* rtl/gatl_pkg.sv */
// Shared constants, codes and helpers for the glyph atlas text layout block.
// No dependencies.
package gatl_pkg;

   localparam int GLYPH_COUNT  = 256;
   localparam int GRID_COLUMNS = 16;
   localparam int CODE_W       = $clog2(GLYPH_COUNT);
   localparam int COL_W        = $clog2(GRID_COLUMNS);
   localparam int ROW_W        = CODE_W - COL_W;

   localparam int COORD_W  = 16;
   localparam int TOTAL_W  = 20;
   localparam int CELL_W   = 9;
   localparam int GWIDTH_W = 8;
   localparam int TEX_W    = 12;
   localparam int TEXE_W   = 13;
   localparam int COLOR_W  = 64;
   localparam int CMD_W    = 2;
   localparam int CSR_IDX_W = 2;

   localparam logic [CMD_W-1:0] CMD_LOAD  = 2'd0;
   localparam logic [CMD_W-1:0] CMD_START = 2'd1;
   localparam logic [CMD_W-1:0] CMD_CHAR  = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_CELL_SIZE  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TEXT_COLOR = 2'd1;

   localparam logic [CODE_W-1:0]  CODE_NEWLINE = 8'd10;
   localparam logic [COORD_W-1:0] COORD_MAX    = 16'hFFFF;
   localparam logic [TOTAL_W-1:0] TOTAL_MAX    = 20'hFFFFF;
   localparam logic [CELL_W-1:0]  CELL_RESET   = 9'd16;
   localparam logic [CELL_W-1:0]  CELL_MAX     = 9'd256;

   // Cell pitch as used: zero acts as one, anything past the max clamps.
   function automatic logic [CELL_W-1:0] eff_cell(input logic [CELL_W-1:0] c);
      logic [CELL_W-1:0] r;
      if (c == '0) begin
         r = CELL_W'(1);
      end else if (c > CELL_MAX) begin
         r = CELL_MAX;
      end else begin
         r = c;
      end
      return r;
   endfunction

endpackage

/* rtl/glyph_atlas_text_layout.sv */
// Glyph atlas text layout: width table in a 256x8 RAM, cursor and running width in flops.
// A sprite passes the stage 1 register, then the output register, which can stall stage 1.
// Throughput: one command per cycle unless stalled; width RAM: one read, one write per cycle.
// Reset: cursor, origin, running width, cell size (16), color (0) and valid flags clear.
// The width table has no reset and no clearing pass; an entry is meaningful once loaded.
// Depends on gatl_pkg and gatl_ram.
module glyph_atlas_text_layout
   import gatl_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   // command channel
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic [CMD_W-1:0]        req_command,
   input  logic [CODE_W-1:0]       req_char_code,
   input  logic [GWIDTH_W-1:0]     req_glyph_width,
   input  logic [COORD_W-1:0]      req_start_x,
   input  logic [COORD_W-1:0]      req_start_y,
   // sprite channel
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic [COORD_W-1:0]      rsp_sprite_x,
   output logic [COORD_W-1:0]      rsp_sprite_y,
   output logic [CELL_W-1:0]       rsp_sprite_w,
   output logic [CELL_W-1:0]       rsp_sprite_h,
   output logic [TEX_W-1:0]        rsp_tex_u0,
   output logic [TEX_W-1:0]        rsp_tex_v0,
   output logic [TEXE_W-1:0]       rsp_tex_u1,
   output logic [TEXE_W-1:0]       rsp_tex_v1,
   output logic [COLOR_W-1:0]      rsp_sprite_color,
   output logic [TOTAL_W-1:0]      rsp_width_total,
   // configuration writes
   input  logic                    csr_we,
   input  logic [CSR_IDX_W-1:0]    csr_index,
   input  logic [COLOR_W-1:0]      csr_wdata
);

   // ---------------------------------------------------------------
   // Configuration registers
   // ---------------------------------------------------------------
   logic [CELL_W-1:0]  cell_size_ff;
   logic [COLOR_W-1:0] text_color_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cell_size_ff  <= CELL_RESET;
         text_color_ff <= '0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_CELL_SIZE:  cell_size_ff  <= csr_wdata[CELL_W-1:0];
            CSR_TEXT_COLOR: text_color_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // ---------------------------------------------------------------
   // Stage 0: transfer. Loads write the width RAM right here; every
   // command reads the RAM at its code. A char read always lands at a
   // later edge than any earlier load's write, so no bypass is needed.
   // ---------------------------------------------------------------
   logic req_xfer;
   logic s1_advance;
   logic s1_valid_ff;

   assign req_ready = !s1_valid_ff || s1_advance;
   assign req_xfer  = req_valid && req_ready;

   logic [GWIDTH_W-1:0] ram_rd_data;

   gatl_ram #(
      .WIDTH (GWIDTH_W),
      .DEPTH (GLYPH_COUNT)
   ) u_width_ram (
      .clock   (clock),
      .wr_en   (req_xfer && (req_command == CMD_LOAD)),
      .wr_addr (req_char_code),
      .wr_data (req_glyph_width),
      .rd_en   (req_xfer),
      .rd_addr (req_char_code),
      .rd_data (ram_rd_data)
   );

   // ---------------------------------------------------------------
   // Stage 1: command with its width byte; cursor state read-modify-write.
   // RAM data holds while stalled since the read only fires on transfer.
   // ---------------------------------------------------------------
   logic [CMD_W-1:0]   s1_cmd_ff;
   logic [CODE_W-1:0]  s1_code_ff;
   logic [COORD_W-1:0] s1_start_x_ff;
   logic [COORD_W-1:0] s1_start_y_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_ready) begin
         s1_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         s1_cmd_ff     <= req_command;
         s1_code_ff    <= req_char_code;
         s1_start_x_ff <= req_start_x;
         s1_start_y_ff <= req_start_y;
      end
   end

   logic [COORD_W-1:0] cursor_x_ff, cursor_x_in;
   logic [COORD_W-1:0] cursor_y_ff, cursor_y_in;
   logic [COORD_W-1:0] origin_x_ff, origin_x_in;
   logic [TOTAL_W-1:0] running_width_ff, running_width_in;

   logic s1_is_char, s1_is_newline, s1_is_glyph, s1_is_start;
   assign s1_is_char    = s1_cmd_ff == CMD_CHAR;
   assign s1_is_newline = s1_is_char && (s1_code_ff == CODE_NEWLINE);
   assign s1_is_glyph   = s1_is_char && !s1_is_newline;
   assign s1_is_start   = s1_cmd_ff == CMD_START;

   logic rsp_valid_ff;
   assign s1_advance = s1_valid_ff && (!s1_is_glyph || !rsp_valid_ff || rsp_ready);

   // sprite arithmetic
   logic [CELL_W-1:0]    cell_pitch;
   logic [CELL_W-1:0]    w;
   logic [COL_W-1:0]     col;
   logic [ROW_W-1:0]     row;
   logic [TEX_W-1:0]     u0, v0;
   logic [TEXE_W-1:0]    u1, v1;
   logic [COORD_W:0]     cx_sum, cy_sum;
   logic [TOTAL_W:0]     tot_sum;

   always_comb begin
      cell_pitch = eff_cell(cell_size_ff);
      w       = CELL_W'(ram_rd_data) + CELL_W'(1);
      col     = s1_code_ff[COL_W-1:0];
      row     = s1_code_ff[CODE_W-1:COL_W];
      u0      = TEX_W'(TEXE_W'(col) * TEXE_W'(cell_pitch));   // at most 15 * 256
      v0      = TEX_W'(TEXE_W'(row) * TEXE_W'(cell_pitch));
      u1      = TEXE_W'(u0) + TEXE_W'(w);
      v1      = TEXE_W'(v0) + TEXE_W'(cell_pitch);
      cx_sum  = {1'b0, cursor_x_ff} + (COORD_W+1)'(w);
      cy_sum  = {1'b0, cursor_y_ff} + (COORD_W+1)'(cell_pitch);
      tot_sum = {1'b0, running_width_ff} + (TOTAL_W+1)'(w);
   end

   logic [TOTAL_W-1:0] total_next;
   assign total_next = tot_sum[TOTAL_W] ? TOTAL_MAX : tot_sum[TOTAL_W-1:0];

   always_comb begin
      cursor_x_in      = cursor_x_ff;
      cursor_y_in      = cursor_y_ff;
      origin_x_in      = origin_x_ff;
      running_width_in = running_width_ff;
      if (s1_advance) begin
         if (s1_is_start) begin
            origin_x_in      = s1_start_x_ff;
            cursor_x_in      = s1_start_x_ff;
            cursor_y_in      = s1_start_y_ff;
            running_width_in = '0;
         end else if (s1_is_newline) begin
            cursor_x_in = origin_x_ff;
            cursor_y_in = cy_sum[COORD_W] ? COORD_MAX : cy_sum[COORD_W-1:0];
         end else if (s1_is_glyph) begin
            cursor_x_in      = cx_sum[COORD_W] ? COORD_MAX : cx_sum[COORD_W-1:0];
            running_width_in = total_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cursor_x_ff      <= '0;
         cursor_y_ff      <= '0;
         origin_x_ff      <= '0;
         running_width_ff <= '0;
      end else begin
         cursor_x_ff      <= cursor_x_in;
         cursor_y_ff      <= cursor_y_in;
         origin_x_ff      <= origin_x_in;
         running_width_ff <= running_width_in;
      end
   end

   // ---------------------------------------------------------------
   // Output register: loads when a glyph leaves stage 1.
   // ---------------------------------------------------------------
   logic rsp_load;
   assign rsp_load = s1_advance && s1_is_glyph;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   logic [COORD_W-1:0] rsp_x_ff, rsp_y_ff;
   logic [CELL_W-1:0]  rsp_w_ff, rsp_h_ff;
   logic [TEX_W-1:0]   rsp_u0_ff, rsp_v0_ff;
   logic [TEXE_W-1:0]  rsp_u1_ff, rsp_v1_ff;
   logic [COLOR_W-1:0] rsp_color_ff;
   logic [TOTAL_W-1:0] rsp_total_ff;

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_x_ff     <= cursor_x_ff;
         rsp_y_ff     <= cursor_y_ff;
         rsp_w_ff     <= w;
         rsp_h_ff     <= cell_pitch;
         rsp_u0_ff    <= u0;
         rsp_v0_ff    <= v0;
         rsp_u1_ff    <= u1;
         rsp_v1_ff    <= v1;
         rsp_color_ff <= text_color_ff;
         rsp_total_ff <= total_next;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_sprite_x     = rsp_x_ff;
   assign rsp_sprite_y     = rsp_y_ff;
   assign rsp_sprite_w     = rsp_w_ff;
   assign rsp_sprite_h     = rsp_h_ff;
   assign rsp_tex_u0       = rsp_u0_ff;
   assign rsp_tex_v0       = rsp_v0_ff;
   assign rsp_tex_u1       = rsp_u1_ff;
   assign rsp_tex_v1       = rsp_v1_ff;
   assign rsp_sprite_color = rsp_color_ff;
   assign rsp_width_total  = rsp_total_ff;

   // ---------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------
`ifndef NO_ASSERTIONS
   // A sprite only appears after a drawn glyph left stage 1.
   a_rsp_from_glyph: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(s1_valid_ff && s1_is_glyph))
      else $error("sprite valid without a glyph leaving stage 1");

   // Only a start command can move the cursor up.
   a_cursor_y_up: assert property (@(posedge clock) disable iff (reset)
      (s1_advance && !s1_is_start) |=> cursor_y_ff >= $past(cursor_y_ff))
      else $error("cursor y decreased without a start command");

   // Drawing a glyph always leaves a nonzero running width.
   a_total_nonzero: assert property (@(posedge clock) disable iff (reset)
      (s1_advance && s1_is_glyph) |=> running_width_ff != '0)
      else $error("running width zero after a glyph");

   // A stalled sprite is never overwritten by stage 1.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ready) |-> !rsp_load)
      else $error("output register overwritten while stalled");
`endif

endmodule

/* rtl/gatl_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module gatl_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
